// ----- rtl/spq_pkg.sv -----
// spq_pkg: shared sizes, operation and status codes, and the
// controller-to-datapath command struct for the sorted priority queue
// no dependencies
package spq_pkg;

	localparam int DEPTH = 8;                    // number of entry slots, 2 to 64
	localparam int CNT_W = $clog2(DEPTH + 1);    // entry count, 0 to DEPTH
	localparam int DATA_W = 32;
	localparam int OCC_W = 4;                    // occupancy field, count modulo 16

	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_DELETE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;  // capture the accepted request
		logic exec;  // apply the captured request and register its result
	} dp_cmd_t;

endpackage

// ----- rtl/spq_if.sv -----
// spq_req_if and spq_rsp_if: valid/ready channels for queue requests
// and results; depends on spq_pkg
interface spq_req_if import spq_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [DATA_W-1:0] item_value;
	logic signed [DATA_W-1:0] item_priority;

	modport source (output valid, func, item_value, item_priority, input ready);
	modport sink (input valid, func, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] removed_value;
	logic [OCC_W-1:0]         occupancy;
	logic                     is_empty_flag;
	logic                     is_full_flag;

	modport source (output valid, status, removed_value, occupancy, is_empty_flag,
		is_full_flag, input ready);
	modport sink (input valid, status, removed_value, occupancy, is_empty_flag,
		is_full_flag, output ready);
endinterface

// ----- rtl/spq_controller.sv -----
// spq_controller: one-hot sequencer that accepts a request, runs it
// through the datapath and holds the result valid; depends on spq_pkg
module spq_controller import spq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q, out_valid_n;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_n     = state_q;
		out_valid_n = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait until the result register is free
				if (slot_free) begin
					cmd.exec    = 1'b1;
					out_valid_n = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/spq_datapath.sv -----
// spq_datapath: sorted cell chain of value/priority slots, entry count,
// request register and result register; depends on spq_pkg
module spq_datapath import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  logic                     func,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] item_priority,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] removed_value,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     is_empty_flag,
	output logic                     is_full_flag
);

	// captured request
	logic                     func_q;
	logic signed [DATA_W-1:0] in_val_q;
	logic signed [DATA_W-1:0] in_pri_q;

	// cell chain, slot 0 is the front
	logic signed [DATA_W-1:0] val_q [DEPTH];
	logic signed [DATA_W-1:0] pri_q [DEPTH];
	logic signed [DATA_W-1:0] val_n [DEPTH];
	logic signed [DATA_W-1:0] pri_n [DEPTH];
	logic [CNT_W-1:0]         count_q, count_n;
	logic [DEPTH-1:0]         stay;   // slot keeps its entry on insert

	logic                     full, empty;
	status_t                  status_n;
	logic signed [DATA_W-1:0] removed_n;

	// result register
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] removed_q;
	logic [OCC_W-1:0]         occ_q;
	logic                     empty_q, full_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			stay[i] = (CNT_W'(i) < count_q) && !(pri_q[i] < in_pri_q);
		end
		for (int i = 0; i < DEPTH; i++) begin
			val_n[i] = val_q[i];
			pri_n[i] = pri_q[i];
		end
		count_n   = count_q;
		status_n  = ST_DONE;
		removed_n = '0;
		if (func_q == FN_INSERT) begin
			if (full) begin
				status_n = ST_FULL;
			end else begin
				// new entry lands at the first slot that does not stay,
				// slots behind it move back by one
				for (int i = 0; i < DEPTH; i++) begin
					if (!stay[i]) begin
						if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
							val_n[i] = in_val_q;
							pri_n[i] = in_pri_q;
						end else begin
							val_n[i] = val_q[(i == 0) ? 0 : i - 1];
							pri_n[i] = pri_q[(i == 0) ? 0 : i - 1];
						end
					end
				end
				count_n = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_n = ST_EMPTY;
			end else begin
				removed_n = val_q[0];
				for (int i = 0; i < DEPTH - 1; i++) begin
					val_n[i] = val_q[i + 1];
					pri_n[i] = pri_q[i + 1];
				end
				count_n = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			in_val_q <= item_value;
			in_pri_q <= item_priority;
		end
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				val_q[i] <= val_n[i];
				pri_q[i] <= pri_n[i];
			end
			status_q  <= status_n;
			removed_q <= removed_n;
			occ_q     <= OCC_W'(count_n);
			empty_q   <= (count_n == '0);
			full_q    <= (count_n == CNT_W'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_n;
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign occupancy     = occ_q;
	assign is_empty_flag = empty_q;
	assign is_full_flag  = full_q;

endmodule

// ----- rtl/sorted_array_priority_queue_top.sv -----
// sequencing: an accepted request is captured, then the execute step applies it and
// registers its result once the result register is free; one request is in flight
// at a time, and a stalled result holds the execute step until it is taken
// the next request is accepted while a finished result waits on the output
// reset: arst_n clears the entry count and handshake state, the queue starts empty
// depends on spq_pkg, spq_if, spq_controller, spq_datapath
module sorted_array_priority_queue_top import spq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	dp_cmd_t cmd;   // load on request accept, exec to apply and register result

	// sequencing: idle accepts, execute waits for a free result register
	spq_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// sorted slots: insert after all equal or higher priorities,
	// delete shifts every slot one toward the front
	spq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.func          (req.func),
		.item_value    (req.item_value),
		.item_priority (req.item_priority),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.occupancy     (rsp.occupancy),
		.is_empty_flag (rsp.is_empty_flag),
		.is_full_flag  (rsp.is_full_flag)
	);

	// one request in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one still executing");

	// a rejected insert means the queue was and stays full
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.is_full_flag && !rsp.is_empty_flag))
		else $error("full rejection without full flag");

	// a rejected delete returns zero on an empty queue
	a_empty_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_EMPTY) |->
		(rsp.is_empty_flag && rsp.removed_value == '0))
		else $error("empty rejection inconsistent");

	// a new result only appears after a request was accepted
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result without a request");

endmodule

// ----- tb/sv/tb_sorted_array_priority_queue_top.sv -----
// self-checking testbench for sorted_array_priority_queue_top: directed table then random traffic,
// each result checked against an in-bench priority queue predictor
// depends on spq_pkg, spq_if and the rtl of sorted_array_priority_queue_top
module tb_sorted_array_priority_queue_top import spq_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 680;
	localparam int IDLE_LIMIT = 500;   // cycles with no request or result taken
	localparam int TAIL_CYCLES = 8;    // settle time after the last result

	// one result as the block reports it
	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] removed_value;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty_flag;
		logic              is_full_flag;
	} qresult_t;

	// one row of the directed table; a fixed row carries its own expected result
	typedef struct packed {
		func_t             func;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] prio;
		logic              fixed;
		qresult_t          want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_array_priority_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state: entries kept sorted, slot 0 is the front
	logic signed [DATA_W-1:0] held_value [DEPTH];
	logic signed [DATA_W-1:0] held_prio [DEPTH];
	int held_count = 0;

	// results owed by the block, oldest first
	qresult_t owed_results [$];
	stim_row_t directed_rows [$];
	int failures = 0;
	bit tx_calm = 0;   // sender runs back to back while set

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one request to the predictor and return what the block should report
	function automatic qresult_t serve_request(input func_t f,
		input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] p);
		qresult_t r;
		int pos;
		int i;
		r = '0;
		r.status = ST_DONE;
		if (f == FN_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// new entry goes behind every entry of equal or higher priority
				pos = 0;
				while (pos < held_count && held_prio[pos] >= p)
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_value[i] = held_value[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_value[pos] = v;
				held_prio[pos] = p;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed_value = held_value[0];
				for (i = 1; i < held_count; i++) begin
					held_value[i-1] = held_value[i];
					held_prio[i-1] = held_prio[i];
				end
				held_count--;
			end
		end
		// occupancy wraps at its field width, the flags do not
		r.occupancy = OCC_W'(held_count);
		r.is_empty_flag = (held_count == 0);
		r.is_full_flag = (held_count == DEPTH);
		return r;
	endfunction

	task automatic add_row(input func_t f, input logic [DATA_W-1:0] v,
		input logic [DATA_W-1:0] p, input bit fixed = 1'b0, input status_t st = ST_DONE,
		input int occ = 0);
		stim_row_t row;
		row.func = f;
		row.value = v;
		row.prio = p;
		row.fixed = fixed;
		row.want.status = st;
		row.want.removed_value = '0;
		row.want.occupancy = OCC_W'(occ);
		row.want.is_empty_flag = (occ == 0);
		row.want.is_full_flag = (occ == DEPTH);
		directed_rows.push_back(row);
	endtask

	// present one request after a random gap and wait for it to be taken;
	// valid stays high when the next request follows without a gap
	task automatic send_request(input func_t f, input logic [DATA_W-1:0] v,
		input logic [DATA_W-1:0] p, output qresult_t predicted);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.item_value <= v;
		req_ch.item_priority <= p;
		do @(posedge clk); while (!req_ch.ready);
		predicted = serve_request(f, v, p);
	endtask

	// hold off the sender until every owed result has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	// priorities lean toward a few small values so ties are common
	function automatic logic [DATA_W-1:0] pick_prio();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return DATA_W'($urandom_range(0, 3));
			4: return 32'h7fff_ffff;
			5: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic check_result(input qresult_t want);
		if (rsp_ch.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
			failures++;
		end
		if (rsp_ch.removed_value !== want.removed_value) begin
			$error("removed_value: expected %0d, got %0d",
				$signed(want.removed_value), rsp_ch.removed_value);
			failures++;
		end
		if (rsp_ch.occupancy !== want.occupancy) begin
			$error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
			failures++;
		end
		if (rsp_ch.is_empty_flag !== want.is_empty_flag) begin
			$error("is_empty_flag: expected %0b, got %0b", want.is_empty_flag,
				rsp_ch.is_empty_flag);
			failures++;
		end
		if (rsp_ch.is_full_flag !== want.is_full_flag) begin
			$error("is_full_flag: expected %0b, got %0b", want.is_full_flag,
				rsp_ch.is_full_flag);
			failures++;
		end
	endtask

	// result side: random stall before each result, with calm stretches
	initial begin
		int stall;
		int served;
		bit rx_calm;
		served = 0;
		rx_calm = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (served % 32 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			stall = rx_calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			served++;
			if (owed_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", rsp_ch.status);
				failures++;
			end else begin
				check_result(owed_results.pop_front());
			end
		end
	end

	// watchdog: ends the run when neither channel moves for too long
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("tb_sorted_array_priority_queue_top failed");
				$finish;
			end
		end
	end

	// request side: reset, directed table, random traffic, drain
	initial begin
		qresult_t got;
		func_t f;
		int mode;
		int insert_pct;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FN_INSERT;
		req_ch.item_value <= '0;
		req_ch.item_priority <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// delete on an empty queue right after reset
		add_row(FN_DELETE, 32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_EMPTY, 0);
		// fill all eight slots with extreme values and priorities
		add_row(FN_INSERT, 32'h7fff_ffff, 32'h0000_0000, 1'b1, ST_DONE, 1);
		add_row(FN_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		add_row(FN_INSERT, 32'h0000_0000, 32'h8000_0000);
		add_row(FN_INSERT, 32'hffff_ffff, 32'h0000_0000);   // ties with the first entry
		add_row(FN_INSERT, 32'h0000_0001, 32'h0000_0000);   // third of the same priority
		add_row(FN_INSERT, 32'h5555_5555, 32'hffff_ffff);
		add_row(FN_INSERT, 32'haaaa_aaaa, 32'h0000_0001);
		add_row(FN_INSERT, 32'h0000_1234, 32'h7fff_ffff);   // ties with the highest
		// insert on a full queue is turned away
		add_row(FN_INSERT, 32'h1111_1111, 32'h7fff_ffff, 1'b1, ST_FULL, DEPTH);
		// empty it again, checking arrival order among equal priorities
		repeat (DEPTH) add_row(FN_DELETE, 32'h0, 32'h0);
		add_row(FN_DELETE, 32'h0000_0000, 32'h8000_0000, 1'b1, ST_EMPTY, 0);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].func, directed_rows[i].value,
				directed_rows[i].prio, got);
			owed_results.push_back(directed_rows[i].fixed ? directed_rows[i].want : got);
		end
		wait_drained();

		// random traffic in stretches that lean toward filling, emptying or neither
		mode = 2;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mode = $urandom_range(0, 2);
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			insert_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
			f = ($urandom_range(0, 99) < insert_pct) ? FN_INSERT : FN_DELETE;
			send_request(f, $urandom(), pick_prio(), got);
			owed_results.push_back(got);
		end

		req_ch.valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb_sorted_array_priority_queue_top passed");
		else
			$display("tb_sorted_array_priority_queue_top failed");
		$finish;
	end

endmodule
